/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the forward kinematics block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/afk_pkg.sv */
// Package for the forward kinematics block: widths, CORDIC constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_W = 16;
  localparam int LEN_W = 16;
  localparam int POS_W = 20;
  localparam int CFG_AW = 5;
  // Q30 values held in 34 bits: |x|,|y| < 1.65, |z| < 1.75 rad in Q30
  localparam int CQ_W = 34;
  localparam int TRIG_W = 16;
  localparam int UNITS_FULL = 46080;
  localparam int UNITS_HALF = 23040;
  localparam int UNITS_QUARTER = 11520;
  localparam longint RAD_SCALE = 149922641;
  localparam longint CORDIC_GAIN = 652032874;
  localparam int TRIG_MAX = 32767;

  // register byte addresses
  localparam logic [CFG_AW-1:0] ADDR_OFS1 = 5'd0;
  localparam logic [CFG_AW-1:0] ADDR_BASE = 5'd4;
  localparam logic [CFG_AW-1:0] ADDR_UPPER = 5'd8;
  localparam logic [CFG_AW-1:0] ADDR_OFS2 = 5'd12;
  localparam logic [CFG_AW-1:0] ADDR_LOWER = 5'd16;

  typedef logic signed [CQ_W-1:0] cq_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  // one lane of the CORDIC pipe
  typedef struct packed {
    cq_t x;
    cq_t y;
    cq_t z;
    logic flip;
  } cstage_t;

  function automatic cq_t atan_q30(input int i);
    cq_t r;
    case (i)
      0: r = 34'sh03243F6A9;
      1: r = 34'sh01DAC6705;
      2: r = 34'sh00FADBAFD;
      3: r = 34'sh007F56EA7;
      4: r = 34'sh003FEAB77;
      5: r = 34'sh001FFD55C;
      6: r = 34'sh000FFFAAB;
      7: r = 34'sh0007FFF55;
      8: r = 34'sh0003FFFEB;
      9: r = 34'sh0001FFFFD;
      default: r = (i < 24) ? cq_t'(34'sh0_4000_0000 >>> i) : '0;
    endcase
    return r;
  endfunction

  // q30 -> q15, ties away from zero, saturated to +-32767, optional negation
  function automatic trig_t q30_to_trig(input cq_t v, input logic flip);
    logic [CQ_W-1:0] mag;
    logic [CQ_W-1:0] rnd;
    logic signed [CQ_W-1:0] r;
    mag = v[CQ_W-1] ? (~v + 1'b1) : v;
    rnd = (mag + (34'd1 << 14)) >> 15;
    if (rnd > CQ_W'(TRIG_MAX)) rnd = CQ_W'(TRIG_MAX);
    r = v[CQ_W-1] ? -$signed(rnd) : $signed(rnd);
    if (flip) r = -r;
    return trig_t'(r);
  endfunction

endpackage

`default_nettype wire

/* rtl/afk_cordic.sv */
// Pipelined rotation-mode CORDIC: any angle in 1/128 degree units in,
// Q1.15 sine and cosine out. Uses afk_pkg. Stalls through a shared enable.
`timescale 1ns / 1ps
`default_nettype none

module afk_cordic (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [17:0]         angle,
  output afk_pkg::trig_t                  sin_o,
  output afk_pkg::trig_t                  cos_o
);

  // front end: wrap, fold, convert to radians (one multiply)
  logic signed [17:0] u_wrap;
  logic signed [17:0] u_fold;
  logic               flip;
  logic signed [47:0] prod;
  logic [47:0]        pmag;
  afk_pkg::cstage_t   st_r [afk_pkg::CORDIC_STEPS+1];
  afk_pkg::cstage_t   st_nxt [afk_pkg::CORDIC_STEPS];
  logic signed [17:0] fold_r;
  logic               flip_r;

  always_comb begin
    u_wrap = angle;
    if (u_wrap >= afk_pkg::UNITS_HALF) u_wrap = u_wrap - 18'(afk_pkg::UNITS_FULL);
    if (u_wrap < -afk_pkg::UNITS_HALF) u_wrap = u_wrap + 18'(afk_pkg::UNITS_FULL);
    flip = 1'b0;
    u_fold = u_wrap;
    if (u_wrap > afk_pkg::UNITS_QUARTER) begin
      u_fold = u_wrap - 18'(afk_pkg::UNITS_HALF);
      flip = 1'b1;
    end else if (u_wrap < -afk_pkg::UNITS_QUARTER) begin
      u_fold = u_wrap + 18'(afk_pkg::UNITS_HALF);
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_r <= u_fold;
      flip_r <= flip;
    end
  end

  always_comb begin
    prod = 48'(fold_r) * 48'(afk_pkg::RAD_SCALE);
    pmag = prod[47] ? (~prod + 1'b1) : prod;
    pmag = (pmag + 48'd512) >> 10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].x <= afk_pkg::cq_t'(afk_pkg::CORDIC_GAIN);
      st_r[0].y <= '0;
      st_r[0].z <= prod[47] ? -$signed(afk_pkg::cq_t'(pmag)) : $signed(afk_pkg::cq_t'(pmag));
      st_r[0].flip <= flip_r;
    end
  end

  // one rotation per register stage
  for (genvar i = 0; i < afk_pkg::CORDIC_STEPS; i++) begin : g_step
    always_comb begin
      st_nxt[i] = st_r[i];
      if (!st_r[i].z[afk_pkg::CQ_W-1]) begin
        st_nxt[i].x = st_r[i].x - (st_r[i].y >>> i);
        st_nxt[i].y = st_r[i].y + (st_r[i].x >>> i);
        st_nxt[i].z = st_r[i].z - afk_pkg::atan_q30(i);
      end else begin
        st_nxt[i].x = st_r[i].x + (st_r[i].y >>> i);
        st_nxt[i].y = st_r[i].y - (st_r[i].x >>> i);
        st_nxt[i].z = st_r[i].z + afk_pkg::atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) st_r[i+1] <= st_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= afk_pkg::q30_to_trig(st_r[afk_pkg::CORDIC_STEPS].x,
                                    st_r[afk_pkg::CORDIC_STEPS].flip);
      sin_o <= afk_pkg::q30_to_trig(st_r[afk_pkg::CORDIC_STEPS].y,
                                    st_r[afk_pkg::CORDIC_STEPS].flip);
    end
  end

endmodule

`default_nettype wire

/* rtl/arm_forward_kinematics.sv */
// Channel  | Dir | Word
// in_      | in  | tdata[15:0] base, [31:16] shoulder, [47:32] elbow
// out_     | out | tdata[19:0] x, [39:20] y, [59:40] z
// cfg_     | in  | APB, five 16-bit length registers at 4*i
// One word accepted per cycle while the output is not stalled; each word passes
// through the CORDIC stage chain, then stages A to D and the output register.
// The whole pipe advances when the output slot is free or empty, so a stall
// holds every stage in place. rst_n clears valid bits, presets lengths.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module arm_forward_kinematics (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // base_angle, shoulder_angle, elbow_angle
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [63:0] out_tdata,  // tip_x, tip_y, tip_z, 4 zero bits
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [afk_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  localparam int TRIG_LAT = afk_pkg::CORDIC_STEPS + 3;
  localparam int LAT = TRIG_LAT + 5;

  logic [afk_pkg::LEN_W-1:0] a1_r, a2_r, a3_r, a4_r, a5_r;
  logic [LAT-1:0] vld_r;
  logic en;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r <= 16'd512;
      a2_r <= 16'd1792;
      a3_r <= 16'd1792;
      a4_r <= 16'd256;
      a5_r <= 16'd1792;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        afk_pkg::ADDR_OFS1:  a1_r <= cfg_pwdata[15:0];
        afk_pkg::ADDR_BASE:  a2_r <= cfg_pwdata[15:0];
        afk_pkg::ADDR_UPPER: a3_r <= cfg_pwdata[15:0];
        afk_pkg::ADDR_OFS2:  a4_r <= cfg_pwdata[15:0];
        afk_pkg::ADDR_LOWER: a5_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      afk_pkg::ADDR_OFS1:  cfg_prdata = {16'd0, a1_r};
      afk_pkg::ADDR_BASE:  cfg_prdata = {16'd0, a2_r};
      afk_pkg::ADDR_UPPER: cfg_prdata = {16'd0, a3_r};
      afk_pkg::ADDR_OFS2:  cfg_prdata = {16'd0, a4_r};
      afk_pkg::ADDR_LOWER: cfg_prdata = {16'd0, a5_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // pipe moves whenever the last slot is empty or being drained
  assign en = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  logic signed [17:0] ang0, ang1, ang12;
  afk_pkg::trig_t s0, c0, s1, c1, s12, c12;

  assign ang0 = 18'($signed(in_tdata[15:0]));
  assign ang1 = 18'($signed(in_tdata[31:16]));
  assign ang12 = 18'($signed(in_tdata[31:16])) + 18'($signed(in_tdata[47:32]));

  afk_cordic u_c0  (.clk(clk), .en(en), .angle(ang0),  .sin_o(s0),  .cos_o(c0));
  afk_cordic u_c1  (.clk(clk), .en(en), .angle(ang1),  .sin_o(s1),  .cos_o(c1));
  afk_cordic u_c12 (.clk(clk), .en(en), .angle(ang12), .sin_o(s12), .cos_o(c12));

  // stage A: link products (Q15)
  logic signed [32:0] p3c_r, p5c_r, p3s_r, p5s_r;
  afk_pkg::trig_t s0_a_r, c0_a_r, s0_b_r, c0_b_r;
  // stage B: reach, z sum
  logic signed [34:0] reach_r;
  logic signed [33:0] zsum_r;
  logic signed [31:0] kq_r;
  // stage C: products in Q30
  logic signed [51:0] rc_r, rs_r, ks_r, kc_r;
  logic signed [33:0] zsum_c_r;
  // stage D: sums
  logic signed [52:0] xs_r, ys_r;
  logic signed [33:0] zsum_d_r;

  localparam int POS_W_F = afk_pkg::POS_W;
  function automatic logic signed [POS_W_F-1:0] rnd_sh(input logic signed [52:0] v,
                                                        input int n);
    logic [52:0] m;
    m = v[52] ? (~v + 1'b1) : v;
    m = (m + (53'd1 << (n - 1))) >> n;
    return v[52] ? -$signed(POS_W_F'(m)) : $signed(POS_W_F'(m));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p3c_r <= $signed({1'b0, a3_r}) * c1;
      p5c_r <= $signed({1'b0, a5_r}) * c12;
      p3s_r <= $signed({1'b0, a3_r}) * s1;
      p5s_r <= $signed({1'b0, a5_r}) * s12;
      s0_a_r <= s0;
      c0_a_r <= c0;
      reach_r <= 35'(p3c_r) + 35'(p5c_r) + $signed({4'd0, a2_r, 15'd0});
      zsum_r <= -(34'(p3s_r) + 34'(p5s_r));
      kq_r <= 32'(($signed({1'b0, a1_r}) - $signed({1'b0, a4_r}))) <<< 15;
      s0_b_r <= s0_a_r;
      c0_b_r <= c0_a_r;
      rc_r <= 52'(reach_r) * 52'(c0_b_r);
      rs_r <= 52'(reach_r) * 52'(s0_b_r);
      ks_r <= 52'(kq_r) * 52'(s0_b_r);
      kc_r <= 52'(kq_r) * 52'(c0_b_r);
      zsum_c_r <= zsum_r;
      xs_r <= 53'(rc_r) + 53'(ks_r);
      ys_r <= 53'(rs_r) - 53'(kc_r);
      zsum_d_r <= zsum_c_r;
      out_tdata <= {4'd0, rnd_sh(53'(zsum_d_r), 15), rnd_sh(ys_r, 30), rnd_sh(xs_r, 30)};
    end
  end

  `ASSERT_IMPL(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, !in_tready,
    "pipe accepted a word while output stalled")
  `ASSERT_NEXT(a_out_keep, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_psel, cfg_pready, "cfg not ready")

endmodule

`default_nettype wire

/* test/arm_forward_kinematics_chk.sv */
// Checker for arm_forward_kinematics: watches the angle, tip and register buses,
// predicts each tip position and compares it. Depends on afk_pkg.
`timescale 1ns / 1ps

module arm_forward_kinematics_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [afk_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          tips_pending
);
  localparam int POS_W = afk_pkg::POS_W;

  typedef struct {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } tip_t;

  tip_t tip_q[$];
  longint len_ofs1, len_base, len_upper, len_ofs2, len_lower;

  function automatic longint rnd_shift(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v < 0) return -((-v + half) >>> n);
    return (v + half) >>> n;
  endfunction

  function automatic longint clamp_trig(longint v);
    if (v > afk_pkg::TRIG_MAX) return afk_pkg::TRIG_MAX;
    if (v < -afk_pkg::TRIG_MAX) return -afk_pkg::TRIG_MAX;
    return v;
  endfunction

  function automatic longint atan_ent(int i);
    longint tbl[10];
    tbl = '{64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFD, 64'h07F56EA7, 64'h03FEAB77,
            64'h01FFD55C, 64'h00FFFAAB, 64'h007FFF55, 64'h003FFFEB, 64'h001FFFFD};
    if (i < 10) return tbl[i];
    return longint'(64'h40000000) >>> i;
  endfunction

  // sine and cosine in Q1.15 of an angle in 1/128 degree units
  task automatic sin_cos(input longint units, output longint s, output longint c);
    longint u, x, y, z, dx, dy;
    bit flip;
    u = units % afk_pkg::UNITS_FULL;
    flip = 0;
    if (u >= afk_pkg::UNITS_HALF) u -= afk_pkg::UNITS_FULL;
    if (u < -afk_pkg::UNITS_HALF) u += afk_pkg::UNITS_FULL;
    if (u > afk_pkg::UNITS_QUARTER) begin
      u -= afk_pkg::UNITS_HALF;
      flip = 1;
    end else if (u < -afk_pkg::UNITS_QUARTER) begin
      u += afk_pkg::UNITS_HALF;
      flip = 1;
    end
    z = rnd_shift(u * afk_pkg::RAD_SCALE, 10);
    x = afk_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < afk_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_ent(i);
      end else begin
        x += dx; y -= dy; z += atan_ent(i);
      end
    end
    c = clamp_trig(rnd_shift(x, 15));
    s = clamp_trig(rnd_shift(y, 15));
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  task automatic predict_tip(input logic [47:0] w, output tip_t t);
    longint t0, t1, t2, s0, c0, s1, c1, s12, c12, reach, kq, px, py, pz;
    t0 = longint'($signed(w[15:0]));
    t1 = longint'($signed(w[31:16]));
    t2 = longint'($signed(w[47:32]));
    sin_cos(t0, s0, c0);
    sin_cos(t1, s1, c1);
    sin_cos(t1 + t2, s12, c12);
    reach = len_upper * c1 + len_lower * c12 + len_base * 32768;
    kq = (len_ofs1 - len_ofs2) * 32768;
    px = reach * c0 + kq * s0;
    py = reach * s0 - kq * c0;
    pz = -(len_upper * s1 + len_lower * s12);
    t.x = POS_W'(rnd_shift(px, 30));
    t.y = POS_W'(rnd_shift(py, 30));
    t.z = POS_W'(rnd_shift(pz, 15));
  endtask

  always @(posedge clk) begin
    tip_t t, e;
    if (!rst_n) begin
      len_ofs1 = 512; len_base = 1792; len_upper = 1792;
      len_ofs2 = 256; len_lower = 1792;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          afk_pkg::ADDR_OFS1:  len_ofs1 = cfg_pwdata[15:0];
          afk_pkg::ADDR_BASE:  len_base = cfg_pwdata[15:0];
          afk_pkg::ADDR_UPPER: len_upper = cfg_pwdata[15:0];
          afk_pkg::ADDR_OFS2:  len_ofs2 = cfg_pwdata[15:0];
          afk_pkg::ADDR_LOWER: len_lower = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_tip(in_tdata, t);
        tip_q.push_back(t);
      end
      if (out_tvalid && out_tready) begin
        if (tip_q.size() == 0) begin
          $display("%0t: tip word with none expected, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          e = tip_q.pop_front();
          if (out_tdata[19:0] !== e.x) begin
            $display("%0t: tip_x expected %h actual %h", $time, e.x, out_tdata[19:0]);
            fail_count++;
          end
          if (out_tdata[39:20] !== e.y) begin
            $display("%0t: tip_y expected %h actual %h", $time, e.y, out_tdata[39:20]);
            fail_count++;
          end
          if (out_tdata[59:40] !== e.z) begin
            $display("%0t: tip_z expected %h actual %h", $time, e.z, out_tdata[59:40]);
            fail_count++;
          end
        end
      end
    end
    tips_pending = tip_q.size();
  end

  initial begin
    fail_count = 0;
    tips_pending = 0;
  end
endmodule

/* test/arm_forward_kinematics_tb.sv */
// Testbench top for arm_forward_kinematics: drives angle words and register
// writes, stalls the tip bus, and gives the verdict. Uses the checker and afk_pkg.
`timescale 1ns / 1ps

module arm_forward_kinematics_tb;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [47:0] in_tdata = '0;  // base_angle, shoulder_angle, elbow_angle
  logic out_tvalid, out_tready = 0;
  logic [63:0] out_tdata;      // tip_x, tip_y, tip_z, zero pad
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [afk_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  int fail_count, tips_pending;
  bit send_quiet, recv_quiet, long_hold;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  arm_forward_kinematics DUT (.*);
  arm_forward_kinematics_chk u_chk (.*);

  initial begin
    #5_000_000;
    $display("arm_forward_kinematics test failed");
    $finish;
  end

  // tip side: random stalls, optional long hold-off
  initial begin
    int d;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready = 0;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end
      d = recv_quiet ? 0 : $urandom_range(0, 9);
      if (d > 0) begin
        out_tready = 0;
        repeat (d) @(negedge clk);
      end
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(input logic [15:0] b, input logic [15:0] s, input logic [15:0] e);
    int gap;
    @(negedge clk);
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {e, s, b};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    wait (tips_pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic reg_write(input logic [afk_pkg::CFG_AW-1:0] a, input logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1; cfg_pwrite = 1; cfg_paddr = a; cfg_pwdata = v; cfg_penable = 0;
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  task automatic set_lengths(input int o1, input int bs, input int up, input int o2,
                             input int lo);
    reg_write(afk_pkg::ADDR_OFS1, o1);
    reg_write(afk_pkg::ADDR_BASE, bs);
    reg_write(afk_pkg::ADDR_UPPER, up);
    reg_write(afk_pkg::ADDR_OFS2, o2);
    reg_write(afk_pkg::ADDR_LOWER, lo);
  endtask

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 46080)) - 23040);
  endfunction

  task automatic random_words(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      send_word(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  initial begin
    logic [15:0] edges[$];
    edges = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520, 16'sd11521,
              -16'sd11521, 16'sd11519, 16'sd32767, -16'sd32768, 16'sd5760, -16'sd1};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset lengths, angle edges, fold and wrap points
    foreach (edges[i]) send_word(edges[i], edges[(i + 3) % edges.size()],
                                 edges[(i + 7) % edges.size()]);
    send_word(16'sd0, 16'sd23040, 16'sd23040);      // shoulder+elbow wraps
    send_word(16'sd0, -16'sd23040, -16'sd23040);
    send_word(16'sd32767, 16'sd32767, 16'sd32767);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768);
    send_word(16'sd0, 16'sd0, 16'sd0);              // full-scale cosine
    random_words(130);
    drain();

    set_lengths(0, 0, 0, 0, 0);
    send_word(16'sd1000, 16'sd2000, 16'sd3000);
    random_words(60);
    drain();

    set_lengths(65535, 65535, 65535, 65535, 65535);
    foreach (edges[i]) send_word(edges[i], edges[i], edges[i]);
    random_words(140);
    drain();

    // negative offset, with a long tip-side hold-off mid stream
    set_lengths(0, 65535, 65535, 65535, 65535);
    reg_write(5'd20, 32'h1234);   // unmapped, ignored
    reg_write(5'd28, 32'hFFFF);
    random_words(30);
    long_hold = 1;
    random_words(120);
    drain();                      // sender pauses until all tips are back
    random_words(60);
    drain();

    set_lengths($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));
    random_words(150);
    drain();

    set_lengths(65535, 0, 300, 0, 65535);
    random_words(120);
    drain();

    if (fail_count == 0)
      $display("arm_forward_kinematics test passed");
    else
      $display("arm_forward_kinematics test failed");
    $finish;
  end
endmodule

/* arm_forward_kinematics.f */
+incdir+rtl
rtl/afk_pkg.sv
rtl/afk_cordic.sv
rtl/arm_forward_kinematics.sv
test/arm_forward_kinematics_chk.sv
test/arm_forward_kinematics_tb.sv
